[sv/bgcd_pkg.sv]
// Shared widths and control types for the binary GCD unit.
`timescale 1ns / 1ps
`default_nettype none

package bgcd_pkg;

    // Working width of the cell row (2 to 64) and width of the operand ports.
    localparam int GCD_W  = 32;
    localparam int OP_W   = 32;
    // Factor-of-two count never exceeds GCD_W-1.
    localparam int TWOS_W = (GCD_W > 2) ? $clog2(GCD_W) : 1;

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic load;     // take a fresh operand pair
        logic step;     // apply one reduction step
        logic shift_x;  // halve the larger value
        logic shift_y;  // halve the smaller value
        logic sub;      // replace the larger value by the difference
        logic lt;       // stored a is below stored b: swap roles
    } t_cell_ctrl;

    // Gathered from the cell row for the sequencer.
    typedef struct packed {
        logic x0;       // parity bit of the larger value
        logic y0;       // parity bit of the smaller value
        logic y_zero;   // smaller value is zero: the pair is reduced
        logic lt;       // borrow out of the top cell
    } t_row_status;

endpackage

`default_nettype wire

[sv/binary_gcd_unit.sv]
// Binary GCD unit: upstream request channel in, result channel out.
// Usage:
//   Present a request on i_operand_a / i_operand_b with i_in_valid; it is
//   taken when o_in_ready is high. o_divisor carries the greatest common
//   divisor, valid while o_out_valid is high, and is taken when i_out_ready
//   is high. gcd(0, 0) returns 0; a single zero operand returns the other.
// Operation:
//   The pair is loaded into a row of GCD_W bit cells on acceptance. In
//   each reduction step the row swaps into order, then halves or subtracts
//   once; when the smaller value reaches zero, the factors of two are
//   restored into the result register. One request is worked at a time.
// Reset:
//   Synchronous, active low; clears the busy flag and result valid.
// Stall:
//   A finished result waits in the output register; a new request is
//   accepted meanwhile, and the row holds its reduced pair until the
//   output register is free.
`timescale 1ns / 1ps
`default_nettype none

module binary_gcd_unit
    import bgcd_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [OP_W-1:0] i_operand_a,
    input  wire logic [OP_W-1:0] i_operand_b,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [OP_W-1:0]      o_divisor
);

    t_cell_ctrl       w_ctrl;
    t_row_status      w_status;
    logic [GCD_W-1:0] w_ld_a;
    logic [GCD_W-1:0] w_ld_b;
    logic [GCD_W-1:0] w_x;
    logic [GCD_W-1:0] w_y;
    logic [GCD_W:0]   w_x_hi;
    logic [GCD_W:0]   w_y_hi;
    logic [GCD_W:0]   w_bab;
    logic [GCD_W:0]   w_bba;

    // Fit the operands to the row width.
    assign w_ld_a = GCD_W'(i_operand_a);
    assign w_ld_b = GCD_W'(i_operand_b);

    // Zero shifts into the top cell; no borrow into the bottom cell.
    assign w_x_hi     = {1'b0, w_x};
    assign w_y_hi     = {1'b0, w_y};
    assign w_bab[0]   = 1'b0;
    assign w_bba[0]   = 1'b0;

    for (genvar g = 0; g < GCD_W; g++) begin : g_cell
        bgcd_cell u_cell (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_ld_a (w_ld_a[g]),
            .i_ld_b (w_ld_b[g]),
            .i_x_hi (w_x_hi[g+1]),
            .i_y_hi (w_y_hi[g+1]),
            .i_bab  (w_bab[g]),
            .i_bba  (w_bba[g]),
            .o_x    (w_x[g]),
            .o_y    (w_y[g]),
            .o_bab  (w_bab[g+1]),
            .o_bba  (w_bba[g+1])
        );
    end

    always_comb begin
        w_status.x0     = w_x[0];
        w_status.y0     = w_y[0];
        w_status.y_zero = ~|w_y;
        w_status.lt     = w_bab[GCD_W];
    end

    bgcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_divisor   (o_divisor),
        .i_status    (w_status),
        .i_x         (w_x),
        .o_ctrl      (w_ctrl)
    );

endmodule

`default_nettype wire

[sv/bgcd_cell.sv]
// One bit slice of the operand pair with its borrow chains and shift links.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_cell
    import bgcd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire t_cell_ctrl i_ctrl,
    input  wire logic       i_ld_a,
    input  wire logic       i_ld_b,
    input  wire logic       i_x_hi,
    input  wire logic       i_y_hi,
    input  wire logic       i_bab,
    input  wire logic       i_bba,
    output logic            o_x,
    output logic            o_y,
    output logic            o_bab,
    output logic            o_bba
);

    logic r_a;
    logic r_b;
    logic n_a;
    logic n_b;
    logic w_d_ab;
    logic w_d_ba;
    logic w_d;

    // Ripple both differences so the larger minus the smaller is ready either way.
    assign w_d_ab = r_a ^ r_b ^ i_bab;
    assign w_d_ba = r_a ^ r_b ^ i_bba;
    assign o_bab  = (~r_a & r_b) | (~(r_a ^ r_b) & i_bab);
    assign o_bba  = (~r_b & r_a) | (~(r_a ^ r_b) & i_bba);

    assign o_x = i_ctrl.lt ? r_b : r_a;
    assign o_y = i_ctrl.lt ? r_a : r_b;
    assign w_d = i_ctrl.lt ? w_d_ba : w_d_ab;

    always_comb begin
        n_a = r_a;
        n_b = r_b;
        if (i_ctrl.load) begin
            n_a = i_ld_a;
            n_b = i_ld_b;
        end else if (i_ctrl.step) begin
            if (i_ctrl.shift_x) begin
                n_a = i_x_hi;
            end else if (i_ctrl.sub) begin
                n_a = w_d;
            end else begin
                n_a = o_x;
            end
            n_b = i_ctrl.shift_y ? i_y_hi : o_y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
    end

endmodule

`default_nettype wire

[sv/bgcd_ctrl.sv]
// Sequencer: request handshake, factor-of-two count and result register.
`timescale 1ns / 1ps
`default_nettype none

module bgcd_ctrl
    import bgcd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [OP_W-1:0]       o_divisor,
    input  wire t_row_status      i_status,
    input  wire logic [GCD_W-1:0] i_x,
    output t_cell_ctrl            o_ctrl
);

    logic              r_busy;
    logic              n_busy;
    logic [TWOS_W-1:0] r_twos;
    logic [TWOS_W-1:0] n_twos;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [OP_W-1:0]   r_divisor;
    logic              w_accept;
    logic              w_step;
    logic              w_finish;
    logic              w_both_even;
    logic [GCD_W-1:0]  w_restored;

    assign w_accept    = i_in_valid & ~r_busy;
    assign w_step      = r_busy & ~i_status.y_zero;
    assign w_finish    = r_busy & i_status.y_zero & (~r_out_valid | i_out_ready);
    assign w_both_even = ~i_status.x0 & ~i_status.y0;
    // Put back the common factors of two.
    assign w_restored  = i_x << r_twos;

    always_comb begin
        o_ctrl.load    = w_accept;
        o_ctrl.step    = w_step;
        o_ctrl.shift_x = ~i_status.x0;
        o_ctrl.shift_y = ~i_status.y0;
        o_ctrl.sub     = i_status.x0 & i_status.y0;
        o_ctrl.lt      = i_status.lt;
    end

    always_comb begin
        n_busy      = r_busy;
        n_twos      = r_twos;
        n_out_valid = r_out_valid;
        if (w_accept) begin
            n_busy = 1'b1;
            n_twos = '0;
        end else if (w_finish) begin
            n_busy = 1'b0;
        end else if (w_step && w_both_even) begin
            n_twos = r_twos + TWOS_W'(1);
        end
        if (w_finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_twos      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_twos      <= n_twos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_divisor <= OP_W'(w_restored);
        end
    end

    assign o_in_ready  = ~r_busy;
    assign o_out_valid = r_out_valid;
    assign o_divisor   = r_divisor;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_busy)
        else $error("request accepted but sequencer not busy");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |=> (r_out_valid && !r_busy))
        else $error("finished pair not presented");

    a_twos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_both_even) |=> (r_twos == $past(r_twos) + TWOS_W'(1)))
        else $error("factor of two not counted");

    a_twos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (32'(r_twos) < 32'(GCD_W)))
        else $error("factor-of-two count out of range");
`endif

endmodule

`default_nettype wire

[test/tb_binary_gcd_unit.sv]
// Self-checking testbench for the binary GCD unit: directed corners and random requests.
`timescale 1ns / 1ps

module tb_binary_gcd_unit;
    import bgcd_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 12;
    localparam int WATCHDOG_CYCLES = 5000;
    localparam int SETTLE_CYCLES   = 2 * GCD_W + 16;
    localparam int RX_STALL_CYCLES = 400;
    localparam int MAX_REPORTS     = 20;
    localparam int RANDOM_REQUESTS = 1450;
    localparam int BURST_REQUESTS  = 250;
    localparam int STALL_REQUESTS  = 12;

    typedef logic [OP_W-1:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word gcd;
    } t_gcd_case;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_word i_operand_a = '0;
    t_word i_operand_b = '0;
    logic  i_out_ready = 1'b0;
    logic  o_in_ready;
    logic  o_out_valid;
    t_word o_divisor;

    t_gcd_case   gcd_queue[$];
    int unsigned requests_sent = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned idle_cycles   = 0;
    int unsigned rx_hold       = 0;
    bit          rx_quiet      = 1'b0;
    bit          tx_quiet      = 1'b0;

    binary_gcd_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_divisor   (o_divisor)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Stein's method on the working width, then cut to the port width.
    function automatic t_word expected_gcd(t_word a_in, t_word b_in);
        logic [63:0] big;
        logic [63:0] lil;
        logic [63:0] tmp;
        logic [63:0] mask;
        logic [63:0] full;
        int          twos;
        mask = (GCD_W >= 64) ? {64{1'b1}} : ((64'd1 << GCD_W) - 64'd1);
        big  = 64'(a_in);
        lil  = 64'(b_in);
        big  = big & mask;
        lil  = lil & mask;
        twos = 0;
        forever begin
            if (big < lil) begin
                tmp = big;
                big = lil;
                lil = tmp;
            end
            if (lil == 0)
                break;
            if (!big[0] && !lil[0]) begin
                big = big >> 1;
                lil = lil >> 1;
                twos++;
            end else if (!big[0]) begin
                big = big >> 1;
            end else if (!lil[0]) begin
                lil = lil >> 1;
            end else begin
                big = big - lil;
            end
        end
        full = (big << twos) & mask;
        return full[OP_W-1:0];
    endfunction

    // Half the time no gap, most others short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(string what, t_word a, t_word b, t_word got, t_word want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] %s: a=%h b=%h got=%h want=%h", $realtime, what, a, b, got, want);
    endtask

    // Returns at the edge on which the request was taken.
    task automatic send_request(t_word a, t_word b);
        int unsigned gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Step past the edge of the last request so it is already queued.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (gcd_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_pair(output t_word a, output t_word b);
        t_word g;
        t_word x;
        t_word y;
        int unsigned s;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                a = $urandom();
                b = $urandom();
            end
            3, 4: begin
                // Shared odd and even factors make the result non-trivial.
                g = $urandom() & ((t_word'(1) << $urandom_range(1, 16)) - 1);
                g = g << $urandom_range(0, 8);
                x = $urandom_range(0, 65535);
                y = $urandom_range(0, 65535);
                a = g * x;
                b = g * y;
            end
            5: begin
                s = $urandom_range(0, OP_W - 1);
                a = t_word'($urandom()) << s;
                b = t_word'($urandom()) << s;
            end
            6: begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            7: begin
                a = $urandom();
                case ($urandom_range(0, 3))
                    0: b = '0;
                    1: b = a;
                    2: b = '1;
                    default: b = 1;
                endcase
            end
            8: begin
                a = t_word'(1) << $urandom_range(0, OP_W - 1);
                b = $urandom();
            end
            default: begin
                b = $urandom() >> $urandom_range(0, OP_W - 1);
                a = b * t_word'($urandom_range(1, 1000));
            end
        endcase
        if ($urandom_range(0, 1)) begin
            x = a;
            a = b;
            b = x;
        end
    endtask

    task automatic test_directed();
        t_word corner_a[$];
        t_word corner_b[$];
        corner_a = '{32'h0, 32'h0, 32'd77, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1,
                     32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h4000_0000,
                     32'hFFFF_FFFF, 32'd12, 32'd18, 32'h1, 32'd2971215073,
                     32'd1836311903, 32'hAAAA_AAAA, 32'hDEAD_BEEF, 32'd6, 32'hFFFF_FFFE};
        corner_b = '{32'h0, 32'd77, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'h1, 32'h8000_0000, 32'h4000_0000, 32'h8000_0000,
                     32'hFFFF_FFFE, 32'd18, 32'd12, 32'h1, 32'd1836311903,
                     32'd2971215073, 32'h5555_5555, 32'hDEAD_BEEF, 32'h8000_0000, 32'h2};
        foreach (corner_a[i])
            send_request(corner_a[i], corner_b[i]);
        wait_for_drain();
    endtask

    task automatic test_random_mixed();
        t_word a;
        t_word b;
        repeat (RANDOM_REQUESTS) begin
            random_pair(a, b);
            send_request(a, b);
        end
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        t_word a;
        t_word b;
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        repeat (BURST_REQUESTS) begin
            random_pair(a, b);
            send_request(a, b);
        end
        wait_for_drain();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Hold the result side so the output register and the row both fill.
    task automatic test_output_backpressure();
        t_word a;
        t_word b;
        rx_hold  = RX_STALL_CYCLES;
        tx_quiet = 1'b1;
        @(posedge i_clk);
        repeat (STALL_REQUESTS) begin
            random_pair(a, b);
            send_request(a, b);
        end
        tx_quiet = 1'b0;
        wait_for_drain();
    endtask

    // Result side: random gaps, or a long hold when one is requested.
    initial begin
        int unsigned gap_left;
        gap_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else if (gap_left > 0) begin
                i_out_ready <= 1'b0;
                gap_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_quiet && $urandom_range(0, 3) == 0)
                    gap_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            gcd_queue.push_back('{a: i_operand_a, b: i_operand_b,
                                  gcd: expected_gcd(i_operand_a, i_operand_b)});
            requests_sent++;
        end
    end

    always @(posedge i_clk) begin
        t_gcd_case want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (gcd_queue.size() == 0) begin
                report_mismatch("unexpected result", '0, '0, o_divisor, '0);
            end else begin
                want = gcd_queue.pop_front();
                if (o_divisor !== want.gcd)
                    report_mismatch("divisor", want.a, want.b, o_divisor, want.gcd);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("[%0t] no handshake for %0d cycles", $realtime, WATCHDOG_CYCLES);
            $display("binary_gcd_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_mixed();
        test_back_to_back();
        test_output_backpressure();

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        foreach (gcd_queue[i])
            report_mismatch("result never came", gcd_queue[i].a, gcd_queue[i].b, '0,
                            gcd_queue[i].gcd);

        $display("covered %0d requests: corner operands, mixed random pairs, back-to-back",
                 requests_sent);
        $display("traffic and a %0d-cycle output stall; %0d results checked, %0d bad",
                 RX_STALL_CYCLES, results_seen, mismatches);
        if (mismatches == 0)
            $display("binary_gcd_unit: match");
        else
            $display("binary_gcd_unit: mismatch");
        $finish;
    end

endmodule
